// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion violated");

// Check a condition that must never be seen out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/core/lifsu_pkg.sv =====
package lifsu_pkg;

  // Field widths of the item and result beats
  localparam int VALUE_W    = 16;
  localparam int IDX_W      = 10;
  localparam int MODE_W     = 2;
  localparam int DECAY_W    = 16;
  localparam int KEEP_W     = DECAY_W + 1;
  localparam int SUM_W      = VALUE_W + 8;
  localparam int FRAC_SHIFT = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_DECAY     = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [DECAY_W-1:0]        DECAY_RST = 16'd58982;
  localparam logic signed [VALUE_W-1:0] THR_RST   = 16'sd4096;
  localparam logic [KEEP_W-1:0]         DECAY_ONE = 17'h10000;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPIKE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EOS   = 2'd2;

  // Result queue
  localparam int            OUTQ_CNT_W = 2;
  localparam logic [OUTQ_CNT_W-1:0] OUTQ_FULL = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         spike_index;
    logic signed [VALUE_W-1:0] weight_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] membrane;
    logic                      was_reset;
  } out_item_t;

  typedef struct packed {
    logic [DECAY_W-1:0]        decay;
    logic signed [VALUE_W-1:0] threshold;
  } cfg_regs_t;

  // What the first pipeline stage holds
  typedef struct packed {
    logic spike;
    logic eos;
  } s1_ctl_t;

endpackage

// ===== rtl/core/lif_neuron_sparse_update.sv =====
// Spike and weight-write beats: one per cycle.
// End-of-step beats: after accept, the result goes to the product
// registers, then to the membrane register and result queue; an end-of-step
// beat waits while another is in stage 1, set by the membrane read-modify-write.
// Reset (rst_n, synchronous): clears spike sum, membrane, pipeline and result
// queue; loads decay and threshold defaults. Weight memory is not cleared.
`include "assert_macros.svh"

module lif_neuron_sparse_update import lifsu_pkg::*; #(
  parameter int NUM_INPUTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // Configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int ADDR_W = $clog2(NUM_INPUTS);
  localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  cfg_regs_t cfg;

  logic              in_acc;
  logic              in_is_eos;
  logic [CMP_W-1:0]  idx_ext;
  logic              idx_hit;
  logic [ADDR_W-1:0] idx_addr;

  s1_ctl_t s1_ctl_r, s1_ctl_nxt;

  logic signed [VALUE_W-1:0] weight_rd;
  logic                      res_vld;
  out_item_t                 res_data;
  logic                      s2_eos;
  logic [OUTQ_CNT_W-1:0]     q_cnt;
  logic [2:0]                outstanding;
  logic                      eos_block;

  // Configuration registers
  lifsu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Index decode: an index past the memory depth drops writes and adds
  // nothing on a spike.
  assign idx_ext  = CMP_W'(in_data.spike_index);
  assign idx_hit  = idx_ext < CMP_W'(NUM_INPUTS);
  assign idx_addr = idx_ext[ADDR_W-1:0];

  // Every result gets a slot in the two-entry result queue before its
  // end-of-step beat is taken: count those in stage 1, stage 2 and queued.
  // An end-of-step beat also waits while another sits in stage 1, since
  // the membrane it reads is written only when that beat leaves stage 2.
  assign outstanding = 3'(s1_ctl_r.eos) + 3'(s2_eos) + 3'(q_cnt);
  assign eos_block   = s1_ctl_r.eos | (outstanding >= 3'(OUTQ_FULL));
  assign in_is_eos   = in_data.mode == MODE_EOS;
  assign in_stall    = in_valid & in_is_eos & eos_block;
  assign in_acc      = in_valid & ~in_stall;

  // Weight memory: a write lands at the accept edge, a spike reads at its
  // accept edge. Each edge carries one beat, so a spike right behind a write
  // to the same index reads the new weight without forwarding.
  lifsu_wmem #(
    .DEPTH  (NUM_INPUTS),
    .ADDR_W (ADDR_W)
  ) u_wmem (
    .clk       (clk),
    .wr_en     (in_acc && (in_data.mode == MODE_WRITE) && idx_hit),
    .wr_addr   (idx_addr),
    .wr_data   (in_data.weight_value),
    .rd_en     (in_acc && (in_data.mode == MODE_SPIKE) && idx_hit),
    .rd_addr   (idx_addr),
    .rd_data_r (weight_rd)
  );

  // Stage 1 tags; unused mode and out-of-range spikes advance as bubbles
  always_comb begin
    s1_ctl_nxt.spike = in_acc && (in_data.mode == MODE_SPIKE) && idx_hit;
    s1_ctl_nxt.eos   = in_acc && in_is_eos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  // Sum accumulate and membrane update
  lifsu_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_ctl   (s1_ctl_r),
    .weight   (weight_rd),
    .res_vld  (res_vld),
    .res_data (res_data),
    .s2_eos   (s2_eos)
  );

  // Result queue parts the result side from the input side
  lifsu_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cnt       (q_cnt)
  );

  // Results in flight never exceed the queue's room
  `ASSERT_ALWAYS(a_credit_bound, clk, rst_n, outstanding <= 3'(OUTQ_FULL))

endmodule

// ===== rtl/core/lifsu_wmem.sv =====
module lifsu_wmem import lifsu_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic signed [VALUE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic signed [VALUE_W-1:0] rd_data_r
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/lifsu_cfg.sv =====
module lifsu_cfg import lifsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_regs_t             cfg
);

  cfg_regs_t cfg_r, cfg_nxt;
  logic      wr_en;
  logic      reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_DECAY:     cfg_nxt.decay     = pwdata[DECAY_W-1:0];
        REG_THRESHOLD: cfg_nxt.threshold = $signed(pwdata[VALUE_W-1:0]);
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay     <= DECAY_RST;
      cfg_r.threshold <= THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DECAY:     prdata = CFG_DATA_W'(cfg_r.decay);
      REG_THRESHOLD: prdata = CFG_DATA_W'(cfg_r.threshold);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/lifsu_update.sv =====
`include "assert_macros.svh"

module lifsu_update import lifsu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_regs_t                 cfg,
  input  s1_ctl_t                   s1_ctl,
  input  logic signed [VALUE_W-1:0] weight,
  output logic                      res_vld,
  output out_item_t                 res_data,
  output logic                      s2_eos
);

  localparam int PK_W  = KEEP_W + SUM_W + 1;
  localparam int PM_W  = DECAY_W + VALUE_W + 1;
  localparam int ACC_W = PK_W + 1;
  localparam int SH_W  = ACC_W - FRAC_SHIFT;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [VALUE_W-1:0] membrane_r;
  logic signed [SUM_W:0]     sum_add;
  logic signed [SUM_W-1:0]   sum_sat;

  logic [KEEP_W-1:0]       keep;
  logic signed [PK_W-1:0]  p_keep, p_keep_r;
  logic signed [PM_W-1:0]  p_mem, p_mem_r;
  logic                    fired, fired_r;
  logic                    s2_eos_r;

  logic signed [ACC_W-1:0]   acc;
  logic signed [SH_W-1:0]    acc_sh;
  logic                      mem_ovf;
  logic signed [VALUE_W-1:0] mem_new;

  // Stage 1: saturating accumulate of the fetched weight
  assign sum_add = (SUM_W+1)'(sum_r) + (SUM_W+1)'(weight);

  always_comb begin
    if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
      sum_sat = sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_add[SUM_W-1:0];
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    if (s1_ctl.eos) begin
      sum_nxt = '0;
    end else if (s1_ctl.spike) begin
      sum_nxt = sum_sat;
    end
  end

  // Stage 1 of end of step: both products, registered
  assign keep   = DECAY_ONE - KEEP_W'(cfg.decay);
  assign p_keep = $signed({1'b0, keep}) * sum_r;
  assign p_mem  = $signed({1'b0, cfg.decay}) * membrane_r;
  assign fired  = membrane_r > cfg.threshold;

  always_ff @(posedge clk) begin
    if (s1_ctl.eos) begin
      p_keep_r <= p_keep;
      p_mem_r  <= fired ? '0 : p_mem;
      fired_r  <= fired;
    end
  end

  // Stage 2: add, round half up, saturate
  assign acc     = ACC_W'(p_keep_r) + ACC_W'(p_mem_r) + ROUND_HALF;
  assign acc_sh  = SH_W'(acc >>> FRAC_SHIFT);
  assign mem_ovf = !((&acc_sh[SH_W-1:VALUE_W-1]) || !(|acc_sh[SH_W-1:VALUE_W-1]));

  always_comb begin
    if (mem_ovf) begin
      mem_new = acc_sh[SH_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      mem_new = acc_sh[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      membrane_r <= '0;
      s2_eos_r   <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      s2_eos_r <= s1_ctl.eos;
      if (s2_eos_r) begin
        membrane_r <= mem_new;
      end
    end
  end

  assign res_vld            = s2_eos_r;
  assign res_data.membrane  = mem_new;
  assign res_data.was_reset = fired_r;
  assign s2_eos             = s2_eos_r;

  // The membrane read in stage 1 must already hold the previous step's result
  `ASSERT_NEVER(a_eos_no_overlap, clk, rst_n, s1_ctl.eos && s2_eos_r)

endmodule

// ===== rtl/core/lifsu_outq.sv =====
`include "assert_macros.svh"

module lifsu_outq import lifsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  out_item_t             push_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  output logic [OUTQ_CNT_W-1:0] cnt
);

  out_item_t                ent_r [2];
  logic                     wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                     pop;

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid & ~out_stall;
  assign out_data  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  assign cnt = cnt_r;

  `ASSERT_NEVER(a_outq_no_overflow, clk, rst_n, push && !pop && (cnt_r == OUTQ_FULL))

endmodule

// ===== tb/lif_neuron_sparse_update_checker.sv =====
module lif_neuron_sparse_update_checker import lifsu_pkg::*; #(
  parameter int N_WEIGHTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    steps_due
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VALUE_W-1:0] weights [N_WEIGHTS];
  logic signed [SUM_W-1:0]   spike_sum;
  logic signed [VALUE_W-1:0] membrane_now;
  logic [DECAY_W-1:0]        decay_q16;
  logic signed [VALUE_W-1:0] threshold;
  out_item_t                 due_membranes[$];
  int                        errs = 0;

  function automatic longint clamp(input longint x, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Advance the neuron by one accepted beat; queue a result on end of step.
  task automatic integrate_beat(input in_item_t b);
    longint    keep;
    longint    acc;
    bit        fired;
    out_item_t res;
    case (b.mode)
      MODE_WRITE: begin
        if (int'(b.spike_index) < N_WEIGHTS) weights[b.spike_index] = b.weight_value;
      end
      MODE_SPIKE: begin
        if (int'(b.spike_index) < N_WEIGHTS)
          spike_sum = SUM_W'(clamp(longint'(spike_sum) + longint'(weights[b.spike_index]),
                                   SUM_W));
      end
      MODE_EOS: begin
        fired = membrane_now > threshold;
        keep  = longint'(DECAY_ONE) - longint'(decay_q16);
        acc   = keep * longint'(spike_sum);
        if (!fired) acc += longint'(decay_q16) * longint'(membrane_now);
        // round half up, then drop the 16 extra fraction bits
        membrane_now  = VALUE_W'(clamp((acc + 32768) >>> FRAC_SHIFT, VALUE_W));
        spike_sum     = '0;
        res.membrane  = membrane_now;
        res.was_reset = fired;
        due_membranes.push_back(res);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      spike_sum    = '0;
      membrane_now = '0;
      decay_q16    = DECAY_RST;
      threshold    = THR_RST;
      due_membranes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_membranes.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, got membrane %0d was_reset %0b",
                   $time, out_data.membrane, out_data.was_reset);
        end else begin
          want = due_membranes.pop_front();
          if (out_data.membrane !== want.membrane) begin
            errs++;
            $display("%0t: membrane mismatch: expected %0d, got %0d",
                     $time, want.membrane, out_data.membrane);
          end
          if (out_data.was_reset !== want.was_reset) begin
            errs++;
            $display("%0t: was_reset mismatch: expected %0b, got %0b",
                     $time, want.was_reset, out_data.was_reset);
          end
        end
      end
      if (in_valid && !in_stall) integrate_beat(in_data);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_DECAY:     decay_q16 = cfg_pwdata[DECAY_W-1:0];
          REG_THRESHOLD: threshold = cfg_pwdata[VALUE_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches <= errs;
    steps_due  <= due_membranes.size();
  end

endmodule

// ===== tb/lif_neuron_sparse_update_tb.sv =====
module lif_neuron_sparse_update_tb import lifsu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode code that the block must drop without a result.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] ADDR_DECAY     = {REG_DECAY, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};

  localparam int N_WEIGHTS    = 1024;
  localparam int N_PHASES     = 8;
  localparam int PHASE_BEATS  = 85;    // random beats per configuration phase
  localparam int SAT_SPIKES   = 260;   // enough max weights to pin the 24-bit sum
  localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off
  localparam int DRAIN_CYCLES = 6;     // result queued after product and membrane registers
  localparam int QUIET_LIMIT  = 2000;
  localparam int CALM_PHASE   = 2;     // no idling on either side here
  localparam int HOLD_PHASE   = 3;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_item_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic calm        = 1'b0;   // suppress random idling on both sides
  logic holdoff_go  = 1'b0;   // ask the receiver for its long hold-off
  int   fails;
  int   steps_due;

  // Weight indexes loaded so far; spikes only ever name one of these.
  bit known [N_WEIGHTS];
  int unsigned known_idx[$];

  lif_neuron_sparse_update #(.NUM_INPUTS(N_WEIGHTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lif_neuron_sparse_update_checker #(.N_WEIGHTS(N_WEIGHTS)) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (fails),
    .steps_due   (steps_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one beat and hold it until the block takes it. Random idle cycles
  // go in front of the beat unless the calm stretch is on.
  task automatic send_beat(input logic [MODE_W-1:0] mode, input int unsigned idx,
                           input logic signed [VALUE_W-1:0] w);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_data.mode         <= mode;
    in_data.spike_index  <= IDX_W'(idx);
    in_data.weight_value <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_weight(input int unsigned idx, input logic signed [VALUE_W-1:0] w);
    send_beat(MODE_WRITE, idx, w);
    if (!known[idx]) begin
      known[idx] = 1'b1;
      known_idx.push_back(idx);
    end
  endtask

  function automatic int unsigned any_known();
    return known_idx[$urandom_range(0, known_idx.size() - 1)];
  endfunction

  // Lean on the extremes; the rest is uniform.
  function automatic logic signed [VALUE_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Drop valid, wait for every outstanding membrane, then let the pipe empty.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (steps_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write in setup, then access; pready is sampled on the access edge.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_neuron(input logic [DECAY_W-1:0] decay,
                            input logic signed [VALUE_W-1:0] thr);
    cfg_write(ADDR_DECAY, CFG_DATA_W'(decay));
    cfg_write(ADDR_THRESHOLD, CFG_DATA_W'(thr));
  endtask

  // Hammer one extreme weight until the running sum pins, then close the step.
  task automatic saturating_step(input logic signed [VALUE_W-1:0] w);
    int unsigned idx;
    idx = $urandom_range(0, N_WEIGHTS - 1);
    load_weight(idx, w);
    repeat (SAT_SPIKES) send_beat(MODE_SPIKE, idx, '0);
    send_beat(MODE_EOS, $urandom_range(0, N_WEIGHTS - 1), VALUE_W'($urandom));
  endtask

  // Mostly well-formed time steps (some loads, some spikes, end of step) with
  // random content; sprinkle in unused-mode beats, stray loads and empty steps.
  task automatic random_steps(input int budget);
    int used;
    int n_spikes;
    int pick;
    used = 0;
    while (used < budget) begin
      if (known_idx.size() == 0 || $urandom_range(99) < 30) begin
        repeat ($urandom_range(1, 4)) begin
          load_weight($urandom_range(0, N_WEIGHTS - 1), pick_weight());
          used++;
        end
      end
      pick = $urandom_range(99);
      if (pick < 12) n_spikes = 0;
      else if (pick < 85) n_spikes = $urandom_range(1, 8);
      else n_spikes = $urandom_range(9, 30);
      repeat (n_spikes) begin
        if ($urandom_range(99) < 4)
          send_beat(MODE_UNUSED, $urandom_range(0, N_WEIGHTS - 1), VALUE_W'($urandom));
        if ($urandom_range(99) < 3) begin
          load_weight($urandom_range(0, N_WEIGHTS - 1), pick_weight());
          used++;
        end
        send_beat(MODE_SPIKE, any_known(), VALUE_W'($urandom));
        used++;
      end
      send_beat(MODE_EOS, $urandom_range(0, N_WEIGHTS - 1), VALUE_W'($urandom));
      used++;
    end
  endtask

  // Result side: random stall, one long hold-off on request, calm stretch off.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_go && !held) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 26);
    end
  end

  // End the run if neither channel nor the register port moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [DECAY_W-1:0]        decay_set [N_PHASES];
    logic signed [VALUE_W-1:0] thr_set [N_PHASES];
    int                        phase;

    // Fixed settings cover the extremes and the defaults; the rest are random.
    decay_set[0] = '0;         thr_set[0] = 16'sh7FFF;
    decay_set[1] = 16'hFFFF;   thr_set[1] = 16'sh8000;
    decay_set[2] = 16'h8000;   thr_set[2] = '0;
    decay_set[4] = DECAY_RST;  thr_set[4] = THR_RST;
    foreach (decay_set[i]) begin
      if (i == 3 || i > 4) begin
        decay_set[i] = DECAY_W'($urandom);
        thr_set[i]   = VALUE_W'($urandom_range(0, 16383) - 8192);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default decay and threshold first.
    load_weight(0, 16'sh7FFF);
    load_weight(N_WEIGHTS - 1, 16'sh8000);
    load_weight(341, 16'sh5555);
    load_weight(682, 16'shAAAA);
    send_beat(MODE_EOS, 0, '0);                     // empty step from rest
    send_beat(MODE_SPIKE, 0, '0);
    send_beat(MODE_SPIKE, 0, '0);
    send_beat(MODE_EOS, 0, '0);                     // climbs above threshold
    send_beat(MODE_EOS, 0, '0);                     // fires and resets
    send_beat(MODE_UNUSED, N_WEIGHTS - 1, 16'shFFFF);
    send_beat(MODE_SPIKE, N_WEIGHTS - 1, '0);
    send_beat(MODE_SPIKE, 341, '0);
    send_beat(MODE_SPIKE, 682, '0);
    send_beat(MODE_EOS, N_WEIGHTS - 1, 16'shFFFF);  // negative sum

    // No leak: the membrane equals the rounded sum, which makes equality and
    // membrane saturation easy to hit.
    settle();
    set_neuron('0, THR_RST);
    load_weight(5, THR_RST);
    send_beat(MODE_SPIKE, 5, '0);
    send_beat(MODE_EOS, 5, '0);                     // lands exactly on threshold
    send_beat(MODE_EOS, 5, '0);                     // equal does not fire
    send_beat(MODE_SPIKE, 0, '0);
    send_beat(MODE_SPIKE, 0, '0);
    send_beat(MODE_EOS, 0, '0);                     // saturates high
    send_beat(MODE_SPIKE, N_WEIGHTS - 1, '0);
    send_beat(MODE_SPIKE, N_WEIGHTS - 1, '0);
    send_beat(MODE_EOS, 0, '0);                     // fires, saturates low
    send_beat(MODE_EOS, 0, '0);

    for (phase = 0; phase < N_PHASES; phase++) begin
      settle();
      set_neuron(decay_set[phase], thr_set[phase]);
      calm <= (phase == CALM_PHASE);
      if (phase == HOLD_PHASE) holdoff_go <= 1'b1;
      if (phase == 0) saturating_step(16'sh7FFF);
      if (phase == 4) saturating_step(16'sh8000);
      random_steps(PHASE_BEATS);
    end

    // Drain every outstanding membrane and give the pipe time to show extras.
    settle();
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
